// File: hw/rtl/swms_pkg.sv
// package for the sliding window mean and deviation block
// holds widths, scale constants and derived sizes; no dependencies
package swms_pkg;

	// window geometry (depth must be a power of two, the final scale is a shift)
	localparam int WINDOW_DEPTH = 512;
	localparam int SAMPLE_BITS  = 10;
	localparam int DEPTH_BITS   = $clog2(WINDOW_DEPTH);

	// accumulator widths
	localparam int SUM_W    = SAMPLE_BITS + DEPTH_BITS;
	localparam int SQ_W     = 2 * SAMPLE_BITS + DEPTH_BITS;
	localparam int SPREAD_W = 2 * SUM_W;

	// 413/128 mV per code, squared scale for the deviation
	localparam int SCALE_NUM   = 413;
	localparam int SCALE_W     = 9;
	localparam int SCALE2      = SCALE_NUM * SCALE_NUM;
	localparam int SCALE2_W    = 18;
	localparam int DEN_SHIFT   = 7 + DEPTH_BITS;
	localparam int MEAN_FULL_W = SUM_W + SCALE_W;

	// radicand and root sizes of the square root unit
	localparam int PROD_W = SPREAD_W + SCALE2_W;
	localparam int ROOT_W = (PROD_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int CNT_W  = $clog2(ROOT_W);

	// result fields
	localparam int MEAN_W   = 12;
	localparam int DEV_W    = 11;
	localparam int MEAN_MAX = (1 << MEAN_W) - 1;
	localparam int DEV_MAX  = (1 << DEV_W) - 1;

	// largest possible running sum, used by checks
	localparam int SUM_MAX = WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DEPTH_BITS-1:0]  slot_t;

endpackage

// File: hw/rtl/sliding_window_mean_stddev_top.sv
// sliding window mean and population deviation of converter codes, in mV
// one sample in flight: a new input is accepted only after the previous result has been
// registered; the deviation comes from the 28-step square root unit (one root bit per cycle)
// reset: ring reads as zero until the first wrap (fill flag), sums and slot clear,
// no clearing pass; depends on swms_pkg, swms_ring, swms_isqrt
module sliding_window_mean_stddev_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [swms_pkg::SAMPLE_BITS-1:0] sample_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swms_pkg::MEAN_W-1:0]     mean_mv,
	output logic [swms_pkg::DEV_W-1:0]      std_dev_mv
);
	import swms_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_SPREAD,
		S_SCALE,
		S_LOAD,
		S_ROOT,
		S_OUT
	} state_t;

	state_t state_q;

	slot_t   slot_q;
	logic    full_q;
	sample_t code_q;
	sample_t ram_rdata;
	logic    ram_we;

	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sq_q;
	logic [SPREAD_W-1:0] spread_s2;
	logic [MEAN_W-1:0]   mean_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic [DEV_W-1:0]    dev_s4;
	logic                out_valid_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [DEV_W-1:0]    dev_q;

	logic                  sq_done;
	logic [ROOT_W-1:0]     sq_root;
	logic                  sq_start;

	sample_t                old_val;
	logic [2*SAMPLE_BITS-1:0] old_sq;
	logic [2*SAMPLE_BITS-1:0] code_sq;
	logic [SPREAD_W-1:0]    nsq;
	logic [SPREAD_W-1:0]    ssq;
	logic [MEAN_FULL_W-1:0] mean_prod;
	logic [MEAN_FULL_W-1:0] mean_full;
	logic [PROD_W-1:0]      prod_full;
	logic [ROOT_W-1:0]      dev_full;

	assign in_ready = (state_q == S_IDLE);
	assign ram_we   = in_valid && in_ready;
	assign sq_start = (state_q == S_LOAD);

	// ring: write new code and read the evicted one in the same cycle
	swms_ring u_ring (
		.clk   (clk),
		.we    (ram_we),
		.addr  (slot_q),
		.wdata (sample_code),
		.rdata (ram_rdata)
	);

	swms_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (prod_s3),
		.done     (sq_done),
		.root     (sq_root)
	);

	// evicted entry counts as zero before the first wrap
	always_comb begin
		old_val   = full_q ? ram_rdata : '0;
		old_sq    = (2*SAMPLE_BITS)'(old_val) * (2*SAMPLE_BITS)'(old_val);
		code_sq   = (2*SAMPLE_BITS)'(code_q) * (2*SAMPLE_BITS)'(code_q);
		nsq       = {sq_q, {DEPTH_BITS{1'b0}}};
		ssq       = SPREAD_W'(sum_q) * SPREAD_W'(sum_q);
		mean_prod = MEAN_FULL_W'(sum_q) * MEAN_FULL_W'(SCALE_NUM);
		mean_full = mean_prod >> DEN_SHIFT;
		prod_full = PROD_W'(spread_s2) * PROD_W'(SCALE2);
		dev_full  = sq_root >> DEN_SHIFT;
	end

	// sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			sq_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// waiting result taken; in S_OUT a new one takes its place
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (slot_q == slot_t'(WINDOW_DEPTH - 1)) begin
							slot_q <= '0;
						end else begin
							slot_q <= slot_q + slot_t'(1);
						end
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					sum_q   <= sum_q - SUM_W'(old_val) + SUM_W'(code_q);
					sq_q    <= sq_q - SQ_W'(old_sq) + SQ_W'(code_sq);
					// last slot just filled, later evictions are real samples
					if (slot_q == '0) begin
						full_q <= 1'b1;
					end
					state_q <= S_SPREAD;
				end
				S_SPREAD: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ram_we) begin
			code_q <= sample_code;
		end
		if (state_q == S_SPREAD) begin
			spread_s2 <= (nsq > ssq) ? nsq - ssq : '0;
			mean_s2   <= (mean_full > MEAN_FULL_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX)
			                                                  : mean_full[MEAN_W-1:0];
		end
		if (state_q == S_SCALE) begin
			prod_s3 <= prod_full;
		end
		if (state_q == S_ROOT && sq_done) begin
			dev_s4 <= (dev_full > ROOT_W'(DEV_MAX)) ? DEV_W'(DEV_MAX) : dev_full[DEV_W-1:0];
		end
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			mean_q <= mean_s2;
			dev_q  <= dev_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_mv    = mean_q;
	assign std_dev_mv = dev_q;

	// one item in flight: no second transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// root completion only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_ROOT)
		else $error("square root finished outside its wait state");

	// running sum never leaves the range of a full window of maximum codes
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(SUM_MAX))
		else $error("running sum out of range");

	// a waiting result is only replaced once it has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("pending result dropped");

endmodule

// File: hw/rtl/swms_ring.sv
// sample ring memory: write and read share one address, registered read data
// depends on swms_pkg
module swms_ring (
	input  logic             clk,
	input  logic             we,
	input  swms_pkg::slot_t  addr,
	input  swms_pkg::sample_t wdata,
	output swms_pkg::sample_t rdata
);
	import swms_pkg::*;

	sample_t mem [WINDOW_DEPTH];

	// read returns the old entry while the new one is written
	always_ff @(posedge clk) begin
		rdata <= mem[addr];
		if (we) begin
			mem[addr] <= wdata;
		end
	end

endmodule

// File: hw/rtl/swms_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on swms_pkg
module swms_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [swms_pkg::PROD_W-1:0] radicand,
	output logic                        done,
	output logic [swms_pkg::ROOT_W-1:0] root
);
	import swms_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ROOT_W+1:0] rem_try;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+1:0] rem_sub;
	logic              fits;

	// one restoring step
	always_comb begin
		rem_try = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
		trial   = {root_q, 2'b01};
		fits    = (rem_try >= trial);
		rem_sub = rem_try - trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[ROOT_W:0] : rem_try[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: dv/sliding_window_mean_stddev_checker.sv
`timescale 1ns / 100ps
// result checker for the sliding window mean and deviation block
// watches both channels, keeps its own copy of the window and compares every result
// depends on swms_pkg
module sliding_window_mean_stddev_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [swms_pkg::SAMPLE_BITS-1:0] sample_code,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [swms_pkg::MEAN_W-1:0]      mean_mv,
	input  logic [swms_pkg::DEV_W-1:0]       std_dev_mv,
	output int                               fail_count,
	output int                               pending_count
);
	import swms_pkg::*;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [DEV_W-1:0]  dev;
	} window_stats_t;

	// window contents and running totals as the block should hold them
	sample_t          window_codes [WINDOW_DEPTH];
	slot_t            next_slot;
	logic [SUM_W-1:0] code_sum;
	logic [SQ_W-1:0]  square_sum;
	window_stats_t    stats_q [$];
	int               mismatches;

	// floor of the square root, one root bit per pass
	function automatic logic [31:0] floor_sqrt(input logic [63:0] radicand);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if ({32'd0, trial} * {32'd0, trial} <= radicand)
				root = trial;
		end
		return root;
	endfunction

	// mean and population deviation in mV from the running totals
	function automatic window_stats_t window_stats(input logic [SUM_W-1:0] total,
			input logic [SQ_W-1:0] square_total);
		logic [63:0] wide_sum;
		logic [63:0] wide_sq;
		logic [63:0] mean_full;
		logic [63:0] n_sq;
		logic [63:0] s_sq;
		logic [63:0] spread;
		logic [63:0] dev_full;
		window_stats_t stats;
		wide_sum  = 64'(total);
		wide_sq   = 64'(square_total);
		mean_full = (wide_sum * 64'(SCALE_NUM)) >> DEN_SHIFT;
		n_sq      = wide_sq * 64'(WINDOW_DEPTH);
		s_sq      = wide_sum * wide_sum;
		// a negative spread cannot happen with consistent totals, clamp anyway
		spread    = (n_sq > s_sq) ? n_sq - s_sq : 64'd0;
		dev_full  = {32'd0, floor_sqrt(spread * 64'(SCALE2))} >> DEN_SHIFT;
		// saturate results that would not fit their field
		stats.mean = (mean_full > 64'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX) : mean_full[MEAN_W-1:0];
		stats.dev  = (dev_full > 64'(DEV_MAX)) ? DEV_W'(DEV_MAX) : dev_full[DEV_W-1:0];
		return stats;
	endfunction

	// result check first, then the new sample enters the window
	always @(posedge clk or negedge arst_n) begin : watch
		sample_t       evicted;
		window_stats_t expected;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window_codes[i] = '0;
			next_slot  = '0;
			code_sum   = '0;
			square_sum = '0;
			mismatches = 0;
			stats_q.delete();
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (stats_q.size() == 0) begin
					$error("result with no sample pending: mean_mv %0d std_dev_mv %0d",
						mean_mv, std_dev_mv);
					mismatches++;
				end else begin
					expected = stats_q.pop_front();
					if (mean_mv !== expected.mean) begin
						$error("mean_mv: expected %0d, actual %0d", expected.mean, mean_mv);
						mismatches++;
					end
					if (std_dev_mv !== expected.dev) begin
						$error("std_dev_mv: expected %0d, actual %0d", expected.dev,
							std_dev_mv);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				// oldest entry leaves, new code takes its slot; slot wraps at depth
				evicted = window_codes[next_slot];
				window_codes[next_slot] = sample_code;
				code_sum   = code_sum - SUM_W'(evicted) + SUM_W'(sample_code);
				square_sum = square_sum - SQ_W'(evicted) * SQ_W'(evicted)
					+ SQ_W'(sample_code) * SQ_W'(sample_code);
				next_slot  = next_slot + slot_t'(1);
				stats_q.push_back(window_stats(code_sum, square_sum));
			end
			fail_count    <= mismatches;
			pending_count <= stats_q.size();
		end
	end

endmodule

// File: dv/sliding_window_mean_stddev_top_test.sv
`timescale 1ns / 100ps
// top of the sliding window mean and deviation testbench: clock, reset, sample
// stimulus in bursts and result back-pressure; depends on swms_pkg, the block
// and sliding_window_mean_stddev_checker
module sliding_window_mean_stddev_top_test;
	import swms_pkg::*;

	localparam int ITEM_COUNT   = 950;
	localparam int IDLE_LIMIT   = 10000;
	localparam int HOLD_START   = 3000;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		SHAPE_UNIFORM,
		SHAPE_EXTREMES,
		SHAPE_HIGH_BAND,
		SHAPE_LOW_BAND,
		SHAPE_FLAT,
		SHAPE_ONE_HOT,
		SHAPE_RAMP
	} code_shape_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	sample_t               sample_code = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [MEAN_W-1:0]     mean_mv;
	logic [DEV_W-1:0]      std_dev_mv;
	int                    fail_count;
	int                    pending_count;
	int                    sent        = 0;
	int                    burst_left  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sliding_window_mean_stddev_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_code (sample_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mean_mv     (mean_mv),
		.std_dev_mv  (std_dev_mv)
	);

	sliding_window_mean_stddev_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_code   (sample_code),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mean_mv       (mean_mv),
		.std_dev_mv    (std_dev_mv),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// one sample per segment step, shaped to stress mean and spread
	function automatic sample_t pick_code(input code_shape_t shape, input sample_t level,
			input int step);
		sample_t one_bit;
		case (shape)
			SHAPE_EXTREMES:  return $urandom_range(0, 1) ? '1 : '0;
			SHAPE_HIGH_BAND: return sample_t'(10'd1023 - $urandom_range(0, 23));
			SHAPE_LOW_BAND:  return sample_t'($urandom_range(0, 23));
			SHAPE_FLAT:      return level;
			SHAPE_ONE_HOT: begin
				one_bit = sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1);
				return $urandom_range(0, 1) ? ~one_bit : one_bit;
			end
			SHAPE_RAMP:      return level + step[SAMPLE_BITS-1:0];
			default:         return sample_t'($urandom_range(0, 1023));
		endcase
	endfunction

	// offer one sample, then close the burst with a random gap, sometimes none, when it runs out
	task automatic offer(input sample_t code);
		int gap;
		in_valid    <= 1'b1;
		sample_code <= code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// result side back-pressure, with one long hold-off to fill the block
	initial begin : result_stall
		int cycle;
		int pattern;
		cycle   = 0;
		pattern = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle == HOLD_START) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycle += HOLD_CYCLES;
			end else begin
				if (cycle % 64 == 0)
					pattern = $urandom_range(0, 3);
				case (pattern)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(0, 1);
					2:       out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= (cycle % 5 != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles with no transfer", IDLE_LIMIT);
		$display("[sliding_window_mean_stddev_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		sample_t     corner_codes [22];
		code_shape_t shape;
		sample_t     level;
		int          seg_len;
		// extremes, alternating full scale, mid-scale neighbors and single bits
		corner_codes = '{
			10'd0, 10'd1023, 10'd0, 10'd1023, 10'd512, 10'd511, 10'd1, 10'd1022,
			10'd1, 10'd2, 10'd4, 10'd8, 10'd16, 10'd32, 10'd64, 10'd128, 10'd256,
			10'd512, 10'h155, 10'h2aa, 10'd1023, 10'd1023
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window still mostly reset zeros here
		foreach (corner_codes[i])
			offer(corner_codes[i]);

		// random segments; the run wraps the window slot once
		while (sent < ITEM_COUNT) begin
			shape   = code_shape_t'($urandom_range(0, 6));
			level   = sample_t'($urandom_range(0, 1023));
			seg_len = $urandom_range(16, 160);
			for (int step = 0; step < seg_len && sent < ITEM_COUNT; step++)
				offer(pick_code(shape, level, step));
		end
		in_valid <= 1'b0;
		@(posedge clk);

		// drain, then allow for the block's latency
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples (%0d corner codes), window wrapped %0d times,",
			sent, $size(corner_codes), sent / WINDOW_DEPTH);
		$display("bursty input and one %0d-cycle result hold-off", HOLD_CYCLES);
		if (fail_count == 0 && pending_count == 0)
			$display("[sliding_window_mean_stddev_top] OK");
		else
			$display("[sliding_window_mean_stddev_top] ERROR");
		$finish;
	end

endmodule
